FILE: design/mp3bf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp3bf_pkg
// shared types, constants and the bitrate table for the first-frame bitrate
// finder
// ----------------------------------------------------------------------------

package mp3bf_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int SEARCH_BITS = 29;
    localparam int CMP_BITS    = OFFSET_BITS + 2;
    localparam int WINDOW_BITS = 24;
    localparam int RATE_BITS   = 9;

    localparam logic [WINDOW_BITS-1:0] ID3_WORD    = 24'h494433;
    localparam logic [SEARCH_BITS-1:0] TAG_HDR_LEN = SEARCH_BITS'(10);
    localparam logic [CMP_BITS-1:0]    SYNC_LEAD   = CMP_BITS'(3);
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX  = {OFFSET_BITS{1'b1}};

    localparam logic [OFFSET_BITS-1:0] OFF_ID3_END    = OFFSET_BITS'(2);
    localparam logic [OFFSET_BITS-1:0] OFF_SIZE_FIRST = OFFSET_BITS'(6);
    localparam logic [OFFSET_BITS-1:0] OFF_SIZE_LAST  = OFFSET_BITS'(9);

    localparam logic [1:0] VERSION_MPEG1 = 2'd3;
    localparam logic [1:0] LAYER_III     = 2'd1;

    typedef enum logic [1:0] {
        STATUS_FOUND  = 2'd0,
        STATUS_FORMAT = 2'd1,
        STATUS_NOSYNC = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PHASE_HEADER = 2'd0,
        PHASE_SEARCH = 2'd1,
        PHASE_DONE   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       start_of_file;
        logic       end_of_file;
    } byte_item_t;

    typedef struct packed {
        status_t              status;
        logic [RATE_BITS-1:0] bitrate_kbps;
    } result_item_t;

    typedef struct packed {
        logic [WINDOW_BITS-1:0] byte_window;
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [SEARCH_BITS-1:0] search_start;
        logic                   tag_present;
        phase_t                 parse_phase;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        byte_window:  '0,
        byte_offset:  '0,
        search_start: '0,
        tag_present:  1'b0,
        parse_phase:  PHASE_HEADER
    };

    function automatic logic [RATE_BITS-1:0] rate_lookup(input logic [3:0] idx);
        logic [RATE_BITS-1:0] rate;
        unique case (idx)
            4'd1:    rate = RATE_BITS'(32);
            4'd2:    rate = RATE_BITS'(40);
            4'd3:    rate = RATE_BITS'(48);
            4'd4:    rate = RATE_BITS'(56);
            4'd5:    rate = RATE_BITS'(64);
            4'd6:    rate = RATE_BITS'(80);
            4'd7:    rate = RATE_BITS'(96);
            4'd8:    rate = RATE_BITS'(112);
            4'd9:    rate = RATE_BITS'(128);
            4'd10:   rate = RATE_BITS'(160);
            4'd11:   rate = RATE_BITS'(192);
            4'd12:   rate = RATE_BITS'(224);
            4'd13:   rate = RATE_BITS'(256);
            4'd14:   rate = RATE_BITS'(320);
            default: rate = '0;
        endcase
        return rate;
    endfunction

endpackage

`default_nettype wire

FILE: design/mp3_first_frame_bitrate_finder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp3_first_frame_bitrate_finder
// finds the first frame sync of a byte stream, skipping a leading tag, and
// reports the frame's bitrate or a status
// ----------------------------------------------------------------------------
//  channel   signals                                  direction   payload
//  bytes     byte_valid, byte_stall, byte_item        sink        byte_item_t
//  results   result_valid, result_stall, result_item  source      result_item_t
//
//  one byte per cycle while byte_stall is low; a result is offered from the result register
//  the parse step sits between the byte register and the result register
//  after reset the parser is in header check at offset 0 with nothing held
//  result_stall holds a waiting result; bytes stall only while the byte
//  register is full and the result register cannot move
// ----------------------------------------------------------------------------

module mp3_first_frame_bitrate_finder (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     byte_valid,
    output logic                     byte_stall,
    input  mp3bf_pkg::byte_item_t    byte_item,
    output logic                     result_valid,
    input  logic                     result_stall,
    output mp3bf_pkg::result_item_t  result_item
);

    logic                     item_valid_reg;
    logic                     item_valid_next;
    mp3bf_pkg::byte_item_t    item_reg;
    mp3bf_pkg::parse_state_t  state_reg;
    mp3bf_pkg::parse_state_t  state_next;
    logic                     result_valid_reg;
    logic                     result_valid_next;
    mp3bf_pkg::result_item_t  result_reg;

    mp3bf_pkg::parse_state_t  step_state;
    logic                     step_hit;
    mp3bf_pkg::result_item_t  step_result;

    logic advance;
    logic accept;
    logic process;

    mp3bf_parser u_parser (
        .state      (state_reg),
        .item       (item_reg),
        .state_next (step_state),
        .hit        (step_hit),
        .result     (step_result)
    );

    assign advance    = !result_valid_reg || !result_stall;
    assign byte_stall = item_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;
    assign process    = item_valid_reg && advance;

    always_comb
    begin
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end

        state_next = process ? step_state : state_reg;

        if (process)
        begin
            result_valid_next = step_hit;
        end
        else if (advance)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= mp3bf_pkg::STATE_CLEAR;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
            state_reg        <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= byte_item;
        end
        if (process && step_hit)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

endmodule

`default_nettype wire

FILE: design/mp3bf_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp3bf_parser
// per-byte parse step: tag header check, syncsafe size, sync search and
// bitrate decode
// ----------------------------------------------------------------------------

module mp3bf_parser (
    input  mp3bf_pkg::parse_state_t state,
    input  mp3bf_pkg::byte_item_t   item,
    output mp3bf_pkg::parse_state_t state_next,
    output logic                    hit,
    output mp3bf_pkg::result_item_t result
);

    mp3bf_pkg::parse_state_t         cur;
    logic [31:0]                     word;
    logic [mp3bf_pkg::OFFSET_BITS-1:0] off;
    logic [mp3bf_pkg::SEARCH_BITS-1:0] size_shift;
    logic                            in_range;
    logic                            sync_hit;

    always_comb
    begin
        cur        = item.start_of_file ? mp3bf_pkg::STATE_CLEAR : state;
        word       = {cur.byte_window, item.file_byte};
        off        = cur.byte_offset;
        size_shift = {cur.search_start[mp3bf_pkg::SEARCH_BITS-8:0], item.file_byte[6:0]};
        in_range   = (mp3bf_pkg::CMP_BITS'(off) >=
                      mp3bf_pkg::CMP_BITS'(cur.search_start) + mp3bf_pkg::SYNC_LEAD);
        sync_hit   = (word[31:21] == '1);

        state_next = cur;
        hit        = 1'b0;
        result     = '{status: mp3bf_pkg::STATUS_NOSYNC, bitrate_kbps: '0};

        if (cur.parse_phase == mp3bf_pkg::PHASE_HEADER ||
            cur.parse_phase == mp3bf_pkg::PHASE_SEARCH)
        begin
            state_next.byte_window = word[mp3bf_pkg::WINDOW_BITS-1:0];
            if (off != mp3bf_pkg::OFFSET_MAX)
            begin
                state_next.byte_offset = off + mp3bf_pkg::OFFSET_BITS'(1);
            end

            if (cur.parse_phase == mp3bf_pkg::PHASE_HEADER)
            begin
                if (off == mp3bf_pkg::OFF_ID3_END)
                begin
                    if (word[mp3bf_pkg::WINDOW_BITS-1:0] == mp3bf_pkg::ID3_WORD)
                    begin
                        state_next.tag_present = 1'b1;
                    end
                    else
                    begin
                        state_next.search_start = '0;
                        state_next.parse_phase  = mp3bf_pkg::PHASE_SEARCH;
                    end
                end
                else if (cur.tag_present && off >= mp3bf_pkg::OFF_SIZE_FIRST &&
                         off <= mp3bf_pkg::OFF_SIZE_LAST)
                begin
                    if (off == mp3bf_pkg::OFF_SIZE_LAST)
                    begin
                        state_next.search_start = size_shift + mp3bf_pkg::TAG_HDR_LEN;
                        state_next.parse_phase  = mp3bf_pkg::PHASE_SEARCH;
                    end
                    else
                    begin
                        state_next.search_start = size_shift;
                    end
                end
            end
            else if (in_range && sync_hit)
            begin
                hit                    = 1'b1;
                state_next.parse_phase = mp3bf_pkg::PHASE_DONE;
                if (word[20:19] != mp3bf_pkg::VERSION_MPEG1 ||
                    word[18:17] != mp3bf_pkg::LAYER_III)
                begin
                    result.status = mp3bf_pkg::STATUS_FORMAT;
                end
                else
                begin
                    result.status       = mp3bf_pkg::STATUS_FOUND;
                    result.bitrate_kbps = mp3bf_pkg::rate_lookup(word[15:12]);
                end
            end

            // end of file with no accepted sync word on this byte
            if (!hit && item.end_of_file)
            begin
                hit                    = 1'b1;
                state_next.parse_phase = mp3bf_pkg::PHASE_DONE;
                result.status          = mp3bf_pkg::STATUS_NOSYNC;
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/mp3_first_frame_bitrate_finder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mp3_first_frame_bitrate_finder_test
// streams whole files, some with a leading tag, through the bitrate finder
// and checks every report against a cycle-free model of the byte parser,
// with random idling on both sides and a long hold-off on the report side
// ----------------------------------------------------------------------------

module mp3_first_frame_bitrate_finder_test;

    localparam int CLOCK_LIMIT  = 200000;
    localparam int ITEMS_PER_RUN = 600;
    localparam int HOLDOFF_CYCLES = 400;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    byte_valid = 1'b0;
    logic                    byte_stall;
    mp3bf_pkg::byte_item_t   byte_item = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    mp3bf_pkg::result_item_t result_item;

    mp3bf_pkg::byte_item_t   byte_stream[$];
    mp3bf_pkg::result_item_t awaited_reports[$];

    // parser model state
    logic [mp3bf_pkg::WINDOW_BITS-1:0] p_window = '0;
    logic [mp3bf_pkg::OFFSET_BITS-1:0] p_offset = '0;
    logic [mp3bf_pkg::SEARCH_BITS-1:0] p_start = '0;
    logic                              p_tag = 1'b0;
    mp3bf_pkg::phase_t                 p_phase = mp3bf_pkg::PHASE_HEADER;

    logic [mp3bf_pkg::RATE_BITS-1:0] kbps_by_index [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
    };

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  send_idle_by_run [3] = '{9, 48, 0};
    int  recv_idle_by_run [3] = '{48, 9, 0};
    bit  holdoff_req = 1'b0;
    bit  holdoff_done = 1'b0;
    int  holdoff_left = 0;
    int  errors = 0;
    int  reports_checked = 0;
    int  status_tally [3] = '{0, 0, 0};
    int  file_bytes_queued = 0;
    int  files_queued = 0;
    int  cycles = 0;

    mp3_first_frame_bitrate_finder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic parse_byte(input mp3bf_pkg::byte_item_t it);
        logic [31:0]             word;
        mp3bf_pkg::result_item_t rep;
        bit                      emit;
        emit = 1'b0;
        rep = '0;
        if (it.start_of_file)
        begin
            p_window = '0;
            p_offset = '0;
            p_start  = '0;
            p_tag    = 1'b0;
            p_phase  = mp3bf_pkg::PHASE_HEADER;
        end
        if (p_phase == mp3bf_pkg::PHASE_HEADER || p_phase == mp3bf_pkg::PHASE_SEARCH)
        begin
            word = {p_window, it.file_byte};
            p_window = word[23:0];
            if (p_phase == mp3bf_pkg::PHASE_HEADER)
            begin
                if (p_offset == mp3bf_pkg::OFF_ID3_END)
                begin
                    if (p_window == mp3bf_pkg::ID3_WORD)
                        p_tag = 1'b1;
                    else
                    begin
                        p_start = '0;
                        p_phase = mp3bf_pkg::PHASE_SEARCH;
                    end
                end
                else if (p_tag && p_offset >= mp3bf_pkg::OFF_SIZE_FIRST &&
                         p_offset <= mp3bf_pkg::OFF_SIZE_LAST)
                begin
                    p_start = {p_start[mp3bf_pkg::SEARCH_BITS-8:0], it.file_byte[6:0]};
                    if (p_offset == mp3bf_pkg::OFF_SIZE_LAST)
                    begin
                        p_start = p_start + mp3bf_pkg::TAG_HDR_LEN;
                        p_phase = mp3bf_pkg::PHASE_SEARCH;
                    end
                end
            end
            else if (64'(p_offset) >= 64'(p_start) + 64'd3 && word[31:21] == 11'h7FF)
            begin
                p_phase = mp3bf_pkg::PHASE_DONE;
                emit = 1'b1;
                if (word[20:19] != mp3bf_pkg::VERSION_MPEG1 ||
                    word[18:17] != mp3bf_pkg::LAYER_III)
                    rep.status = mp3bf_pkg::STATUS_FORMAT;
                else
                begin
                    rep.status = mp3bf_pkg::STATUS_FOUND;
                    rep.bitrate_kbps = kbps_by_index[word[15:12]];
                end
            end
            if (p_offset != {mp3bf_pkg::OFFSET_BITS{1'b1}})
                p_offset = p_offset + mp3bf_pkg::OFFSET_BITS'(1);
            if (!emit && it.end_of_file)
            begin
                p_phase = mp3bf_pkg::PHASE_DONE;
                emit = 1'b1;
                rep.status = mp3bf_pkg::STATUS_NOSYNC;
            end
        end
        if (emit)
            awaited_reports.push_back(rep);
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic sof, input logic eof);
        mp3bf_pkg::byte_item_t it;
        it.file_byte = b;
        it.start_of_file = sof;
        it.end_of_file = eof;
        byte_stream.push_back(it);
    endtask

    task automatic queue_random_file();
        logic [7:0]  body[$];
        logic [27:0] id3_len;
        logic [31:0] hdr;
        int          kind;
        int          content_len;
        int          cut;
        int          pos;
        bit          has_tag;
        bit          no_sync;
        bit          good;
        kind    = $urandom_range(99);
        has_tag = (kind < 40);
        no_sync = (kind >= 80 && kind < 90);
        if (has_tag)
        begin
            if ($urandom_range(99) < 12)
            begin
                id3_len = 28'($urandom_range(28'h0FFF_FFFF, 41));
                content_len = $urandom_range(30);
            end
            else
            begin
                id3_len = 28'($urandom_range(40));
                content_len = int'(id3_len);
                if (id3_len >= 28'd2 && $urandom_range(3) == 0)
                    content_len = int'(id3_len) - int'($urandom_range(2));
            end
            body.push_back(8'h49);
            body.push_back(8'h44);
            body.push_back(8'h33);
            repeat (3) body.push_back(8'($urandom));
            body.push_back({1'($urandom), id3_len[27:21]});
            body.push_back({1'($urandom), id3_len[20:14]});
            body.push_back({1'($urandom), id3_len[13:7]});
            body.push_back({1'($urandom), id3_len[6:0]});
            repeat (content_len) body.push_back(8'($urandom));
            // a sync word hidden in the tag must be skipped
            if (content_len >= 4 && $urandom_range(1))
            begin
                pos = 10 + $urandom_range(content_len - 4);
                body[pos]     = 8'hFF;
                body[pos + 1] = 8'hFB;
                body[pos + 2] = 8'h90;
                body[pos + 3] = 8'h00;
            end
        end
        if (no_sync)
            repeat ($urandom_range(20, 1)) body.push_back(8'($urandom_range(254)));
        else
        begin
            repeat ($urandom_range(12)) body.push_back(8'($urandom));
            good = ($urandom_range(3) != 0);
            hdr = {11'h7FF,
                   good ? mp3bf_pkg::VERSION_MPEG1 : 2'($urandom),
                   good ? mp3bf_pkg::LAYER_III : 2'($urandom),
                   17'($urandom)};
            body.push_back(hdr[31:24]);
            body.push_back(hdr[23:16]);
            body.push_back(hdr[15:8]);
            body.push_back(hdr[7:0]);
            repeat ($urandom_range(8)) body.push_back(8'($urandom));
        end
        if (kind >= 90)
        begin
            cut = $urandom_range(10, 1);
            while (body.size() > cut)
                body.delete(body.size() - 1);
        end
        for (int i = 0; i < body.size(); i++)
            queue_byte(body[i], i == 0,
                       i == body.size() - 1 && $urandom_range(99) >= 5);
        file_bytes_queued += body.size();
        files_queued++;
        // stray bytes between files
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(3, 1)) queue_byte(8'($urandom), 1'b0, 1'($urandom));
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        while (byte_stream.size() != 0 || byte_valid || awaited_reports.size() != 0)
            @(negedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_item  <= '0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                parse_byte(byte_item);
            if (!byte_valid || !byte_stall)
            begin
                if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    byte_item  <= byte_stream.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        mp3bf_pkg::result_item_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_reports.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected report, status %0d kbps %0d", $time,
                             result_item.status, result_item.bitrate_kbps);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (result_item.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, result_item.status);
                    end
                    if (result_item.bitrate_kbps !== want.bitrate_kbps)
                    begin
                        errors++;
                        $display("%0t: bitrate_kbps expected %0d actual %0d", $time,
                                 want.bitrate_kbps, result_item.bitrate_kbps);
                    end
                    reports_checked++;
                    status_tally[int'(want.status)]++;
                end
            end
            if (holdoff_req && !holdoff_done)
            begin
                holdoff_done <= 1'b1;
                holdoff_left <= HOLDOFF_CYCLES;
                result_stall <= 1'b1;
            end
            else if (holdoff_left > 0)
            begin
                holdoff_left <= holdoff_left - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CLOCK_LIMIT)
        begin
            $display("%0t: timed out with %0d reports outstanding", $time,
                     awaited_reports.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // stream opening without a start mark
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'hFB, 1'b0, 1'b0);
        queue_byte(8'h90, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        // ignored after the report, end mark included
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b1);
        // one-byte file
        queue_byte(8'hFF, 1'b1, 1'b1);
        // file ends before the tag size is known
        queue_byte(8'h49, 1'b1, 1'b0);
        queue_byte(8'h44, 1'b0, 1'b0);
        queue_byte(8'h33, 1'b0, 1'b0);
        queue_byte(8'h03, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b1);
        // wrong format, sync completed by the end byte
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(8'hF2, 1'b0, 1'b0);
        queue_byte(8'hE4, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b1);
        // highest bitrate, file left without an end mark
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(8'hFB, 1'b0, 1'b0);
        queue_byte(8'hE0, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        // bad bitrate index
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(8'hFB, 1'b0, 1'b0);
        queue_byte(8'hF4, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b1);
        wait_until_drained();

        for (int run = 0; run < 3; run++)
        begin
            send_idle_pct = send_idle_by_run[run];
            recv_idle_pct = recv_idle_by_run[run];
            if (run == 2)
                holdoff_req = 1'b1;
            file_bytes_queued = 0;
            while (file_bytes_queued < ITEMS_PER_RUN)
                queue_random_file();
            wait_until_drained();
        end

        repeat (16) @(posedge clk);
        $display("streamed %0d random files plus directed cases over %0d cycles",
                 files_queued, cycles);
        $display("checked %0d reports: %0d bitrates, %0d wrong format, %0d no sync",
                 reports_checked,
                 status_tally[int'(mp3bf_pkg::STATUS_FOUND)],
                 status_tally[int'(mp3bf_pkg::STATUS_FORMAT)],
                 status_tally[int'(mp3bf_pkg::STATUS_NOSYNC)]);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
